### hw/rtl/dmfp_pkg.sv
// ----------------------------------------------------------------------------
// DNS message field parser package
// Shared types and codes for the parse phases, sections, field codes and
// error codes of the DNS message field parser.
// ----------------------------------------------------------------------------
package dmfp_pkg;

	typedef enum logic [3:0] {
		PH_HEADER  = 4'd0,
		PH_QNAME   = 4'd1,
		PH_QTYPE   = 4'd2,
		PH_QCLASS  = 4'd3,
		PH_ANAME   = 4'd4,
		PH_ATYPE   = 4'd5,
		PH_ACLASS  = 4'd6,
		PH_ATTL    = 4'd7,
		PH_ARDLEN  = 4'd8,
		PH_RDATA   = 4'd9,
		PH_IGNORED = 4'd10,
		PH_ERROR   = 4'd11
	} phase_t;

	typedef enum logic [1:0] {
		SEC_HEADER   = 2'd0,
		SEC_QUESTION = 2'd1,
		SEC_ANSWER   = 2'd2,
		SEC_IGNORED  = 2'd3
	} section_t;

	typedef enum logic [3:0] {
		FC_NONE      = 4'd0,
		FC_ID        = 4'd1,
		FC_FLAGS     = 4'd2,
		FC_QDCOUNT   = 4'd3,
		FC_ANCOUNT   = 4'd4,
		FC_NSCOUNT   = 4'd5,
		FC_ARCOUNT   = 4'd6,
		FC_LABEL_LEN = 4'd7,
		FC_NAME_CHAR = 4'd8,
		FC_NAME_END  = 4'd9,
		FC_POINTER   = 4'd10,
		FC_TYPE      = 4'd11,
		FC_CLASS     = 4'd12,
		FC_TTL       = 4'd13,
		FC_RDLENGTH  = 4'd14,
		FC_RDATA     = 4'd15
	} field_code_t;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_LABEL     = 2'd1,
		ERR_EARLY_END = 2'd2
	} parse_error_t;

	localparam logic [3:0] HDR_LAST_IDX  = 4'd11;
	localparam logic [3:0] LEN_SHORT     = 4'd2;
	localparam logic [3:0] LEN_TTL       = 4'd4;
	localparam logic [7:0] PTR_TAG_MASK  = 8'hC0;
	localparam logic [7:0] LABEL_MAX     = 8'h3F;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  byte_in_field;
		logic [15:0] bytes_left;
		logic [31:0] acc;
		logic [15:0] questions_left;
		logic        has_answer;
		logic [3:0]  header_idx;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{phase: PH_HEADER, default: '0};

	typedef struct packed {
		section_t     section;
		field_code_t  field_code;
		logic [31:0]  field_value;
		logic         query_response;
		logic [3:0]   op_code;
		logic         authoritative;
		logic         truncated;
		logic         recursion_desired;
		logic         recursion_available;
		logic [3:0]   response_code;
		parse_error_t parse_error;
		logic         packet_done;
	} parse_result_t;

endpackage

### hw/rtl/dmfp_decode.sv
// ----------------------------------------------------------------------------
// DNS message field parser byte decoder
// Combinational step of the parser: from the current parse state and one
// message byte it forms the next state and the result for that byte.
// ----------------------------------------------------------------------------
module dmfp_decode import dmfp_pkg::*; (
	input  parse_state_t  st,
	input  logic [7:0]    packet_byte,
	input  logic          end_of_packet,
	output parse_state_t  nxt,
	output parse_result_t res
);

	always_comb begin
		logic [15:0]  hdr_word;
		logic [31:0]  acc_sh;
		logic [3:0]   bif_inc;
		logic [3:0]   fld_len;
		logic [15:0]  qleft_dec;
		logic [15:0]  blft_dec;
		logic [15:0]  qleft_new;
		logic         has_ans_new;
		logic [31:0]  val;
		logic         flags;
		section_t     sec;
		field_code_t  code;
		parse_error_t err;
		phase_t       after_q;
		phase_t       next_type;

		hdr_word    = {st.acc[7:0], packet_byte};
		acc_sh      = {st.acc[23:0], packet_byte};
		bif_inc     = st.byte_in_field + 4'd1;
		fld_len     = (st.phase == PH_ATTL) ? LEN_TTL : LEN_SHORT;
		qleft_dec   = st.questions_left - 16'd1;
		blft_dec    = st.bytes_left - 16'd1;
		qleft_new   = st.questions_left;
		has_ans_new = st.has_answer;
		after_q     = st.has_answer ? PH_ANAME : PH_IGNORED;
		next_type   = (st.phase == PH_QNAME) ? PH_QTYPE : PH_ATYPE;

		nxt   = st;
		val   = '0;
		flags = 1'b0;
		sec   = SEC_IGNORED;
		code  = FC_NONE;
		err   = ERR_OK;

		case (st.phase)
			PH_HEADER: begin
				sec = SEC_HEADER;
				nxt.acc = {16'd0, hdr_word};
				if (st.header_idx[0]) begin
					code = field_code_t'({1'b0, st.header_idx[3:1]} + 4'd1);
					val  = {16'd0, hdr_word};
					if (code == FC_FLAGS) begin
						flags = 1'b1;
					end
					if (code == FC_QDCOUNT) begin
						qleft_new = hdr_word;
					end
					if (code == FC_ANCOUNT) begin
						has_ans_new = |hdr_word;
					end
					nxt.acc = '0;
				end
				nxt.questions_left = qleft_new;
				nxt.has_answer     = has_ans_new;
				if (st.header_idx >= HDR_LAST_IDX) begin
					nxt.header_idx = '0;
					if (qleft_new != 16'd0) begin
						nxt.phase = PH_QNAME;
					end else begin
						nxt.phase = has_ans_new ? PH_ANAME : PH_IGNORED;
					end
				end else begin
					nxt.header_idx = st.header_idx + 4'd1;
				end
			end
			PH_QNAME, PH_ANAME: begin
				sec = (st.phase == PH_QNAME) ? SEC_QUESTION : SEC_ANSWER;
				if (st.byte_in_field != 4'd0) begin
					code = FC_POINTER;
					val  = {18'd0, st.acc[5:0], packet_byte};
					nxt.byte_in_field = '0;
					nxt.acc = '0;
					nxt.phase = next_type;
				end else if (st.bytes_left != 16'd0) begin
					code = FC_NAME_CHAR;
					val  = {24'd0, packet_byte};
					nxt.bytes_left = blft_dec;
				end else if (packet_byte == 8'd0) begin
					code = FC_NAME_END;
					nxt.phase = next_type;
				end else if ((packet_byte & PTR_TAG_MASK) == PTR_TAG_MASK) begin
					nxt.acc = {24'd0, packet_byte};
					nxt.byte_in_field = 4'd1;
				end else if (packet_byte > LABEL_MAX) begin
					err = ERR_LABEL;
					nxt.phase = PH_ERROR;
				end else begin
					code = FC_LABEL_LEN;
					val  = {24'd0, packet_byte};
					nxt.bytes_left = {8'd0, packet_byte};
				end
			end
			PH_QTYPE, PH_QCLASS, PH_ATYPE, PH_ACLASS, PH_ATTL, PH_ARDLEN: begin
				sec = (st.phase == PH_QTYPE || st.phase == PH_QCLASS) ?
					SEC_QUESTION : SEC_ANSWER;
				nxt.acc = acc_sh;
				nxt.byte_in_field = bif_inc;
				if (bif_inc >= fld_len) begin
					val = acc_sh;
					nxt.acc = '0;
					nxt.byte_in_field = '0;
					case (st.phase)
						PH_QTYPE: begin
							code = FC_TYPE;
							nxt.phase = PH_QCLASS;
						end
						PH_ATYPE: begin
							code = FC_TYPE;
							nxt.phase = PH_ACLASS;
						end
						PH_QCLASS: begin
							code = FC_CLASS;
							nxt.questions_left = qleft_dec;
							nxt.phase = (qleft_dec != 16'd0) ? PH_QNAME : after_q;
						end
						PH_ACLASS: begin
							code = FC_CLASS;
							nxt.phase = PH_ATTL;
						end
						PH_ATTL: begin
							code = FC_TTL;
							nxt.phase = PH_ARDLEN;
						end
						default: begin
							code = FC_RDLENGTH;
							val  = {16'd0, acc_sh[15:0]};
							nxt.bytes_left = acc_sh[15:0];
							nxt.phase = (acc_sh[15:0] != 16'd0) ? PH_RDATA : PH_IGNORED;
						end
					endcase
				end
			end
			PH_RDATA: begin
				sec  = SEC_ANSWER;
				code = FC_RDATA;
				val  = {24'd0, packet_byte};
				nxt.bytes_left = blft_dec;
				if (blft_dec == 16'd0) begin
					nxt.phase = PH_IGNORED;
				end
			end
			default: begin
				sec = SEC_IGNORED;
			end
		endcase

		if (end_of_packet) begin
			if (err == ERR_OK && st.phase != PH_ERROR && nxt.phase != PH_IGNORED) begin
				err = ERR_EARLY_END;
			end
			nxt = STATE_RESET;
		end

		res.section             = sec;
		res.field_code          = code;
		res.field_value         = val;
		res.query_response      = flags & val[15];
		res.op_code             = flags ? val[14:11] : 4'd0;
		res.authoritative       = flags & val[10];
		res.truncated           = flags & val[9];
		res.recursion_desired   = flags & val[8];
		res.recursion_available = flags & val[7];
		res.response_code       = flags ? val[3:0] : 4'd0;
		res.parse_error         = err;
		res.packet_done         = end_of_packet;
	end

endmodule

### hw/rtl/dns_message_field_parser_unit.sv
// ----------------------------------------------------------------------------
// DNS message field parser
// Streaming parser that tags and decodes every byte of a DNS message.
// ----------------------------------------------------------------------------
// The input channel carries one message byte per transfer with an
// end-of-packet mark on the last byte. The output channel gives exactly one
// result per input byte: its section, the field it completes and that
// field's value, the decoded flag bits, an error code and the end mark.
// A byte is held in an input register, then the decoder updates the parse
// state and loads the result register once the output register is free.
// One byte is taken every cycle while the receiver does not stall;
// the rate is set by the combinational state update in the decoder.
// When the receiver stalls, the held result stays on the output, the input
// register keeps its byte, and in_ready drops once both are occupied.
// Reset empties both registers and puts the parser back at the start of a
// message header; after each end-of-packet byte it returns there as well.
// ----------------------------------------------------------------------------
module dns_message_field_parser_unit import dmfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  packet_byte,
	input  logic        end_of_packet,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  section,
	output logic [3:0]  field_code,
	output logic [31:0] field_value,
	output logic        query_response,
	output logic [3:0]  op_code,
	output logic        authoritative,
	output logic        truncated,
	output logic        recursion_desired,
	output logic        recursion_available,
	output logic [3:0]  response_code,
	output logic [1:0]  parse_error,
	output logic        packet_done
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          eop_s1;
	logic          out_valid_q;
	parse_result_t result_q;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t result_nxt;
	logic          out_free;
	logic          advance;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	dmfp_decode u_decode (
		.st            (state_q),
		.packet_byte   (byte_s1),
		.end_of_packet (eop_s1),
		.nxt           (state_nxt),
		.res           (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= STATE_RESET;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= packet_byte;
			eop_s1  <= end_of_packet;
		end
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign out_valid           = out_valid_q;
	assign section             = result_q.section;
	assign field_code          = result_q.field_code;
	assign field_value         = result_q.field_value;
	assign query_response      = result_q.query_response;
	assign op_code             = result_q.op_code;
	assign authoritative       = result_q.authoritative;
	assign truncated           = result_q.truncated;
	assign recursion_desired   = result_q.recursion_desired;
	assign recursion_available = result_q.recursion_available;
	assign response_code       = result_q.response_code;
	assign parse_error         = result_q.parse_error;
	assign packet_done         = result_q.packet_done;

endmodule

### hw/rtl/dmfp_checker.sv
// ----------------------------------------------------------------------------
// DNS message field parser checker
// Concurrent assertions on the parser's ports, bound to the top level.
// ----------------------------------------------------------------------------
module dmfp_checker import dmfp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  section,
	input logic [3:0]  field_code,
	input logic [31:0] field_value,
	input logic        query_response,
	input logic [3:0]  op_code,
	input logic        authoritative,
	input logic        truncated,
	input logic        recursion_desired,
	input logic        recursion_available,
	input logic [3:0]  response_code,
	input logic [1:0]  parse_error,
	input logic        packet_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(field_value)
			&& $stable(field_code) && $stable(section) && $stable(packet_done))
		else $error("result changed while stalled");

	a_flags_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_code != FC_FLAGS |-> !query_response && op_code == 4'd0
			&& !authoritative && !truncated && !recursion_desired
			&& !recursion_available && response_code == 4'd0)
		else $error("flag bits set outside the flags field");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (field_code == FC_NONE || field_code == FC_NAME_END)
			|-> field_value == 32'd0)
		else $error("value given for a byte that completes no field");

	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> parse_error != 2'd3
			&& (section != SEC_HEADER || parse_error != ERR_LABEL)
			&& (packet_done || parse_error != ERR_EARLY_END))
		else $error("error code inconsistent with section or end mark");

	a_rdata_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_code == FC_RDATA |-> section == SEC_ANSWER
			&& field_value[31:8] == 24'd0)
		else $error("rdata byte outside the answer or wider than a byte");

endmodule

bind dns_message_field_parser_unit dmfp_checker u_dmfp_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.out_valid           (out_valid),
	.out_ready           (out_ready),
	.section             (section),
	.field_code          (field_code),
	.field_value         (field_value),
	.query_response      (query_response),
	.op_code             (op_code),
	.authoritative       (authoritative),
	.truncated           (truncated),
	.recursion_desired   (recursion_desired),
	.recursion_available (recursion_available),
	.response_code       (response_code),
	.parse_error         (parse_error),
	.packet_done         (packet_done)
);

### verif/dns_message_field_parser_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message field parser testbench
// Streams DNS messages into the parser one byte per transfer: a few directed
// messages, then random well-formed, truncated, bad-label and noise messages.
// A scoreboard tracks the parse state, predicts the result of every byte and
// compares each result transfer field by field.
// ----------------------------------------------------------------------------
module dns_message_field_parser_unit_test;
	import dmfp_pkg::*;

	localparam int ITEM_TARGET = 1200;
	localparam int CYCLE_LIMIT = 400000;

	class dns_field_checker;
		phase_t        phase;
		logic [3:0]    field_pos;
		logic [15:0]   bytes_left;
		logic [31:0]   acc;
		logic [15:0]   questions_left;
		logic [15:0]   answers;
		logic [3:0]    hdr_idx;
		parse_result_t expected[$];
		int            mismatches;
		int            result_no;

		function new();
			clear_state();
			mismatches = 0;
			result_no = 0;
		endfunction

		function void clear_state();
			phase = PH_HEADER;
			field_pos = '0;
			bytes_left = '0;
			acc = '0;
			questions_left = '0;
			answers = '0;
			hdr_idx = '0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function phase_t after_questions();
			return (answers != 0) ? PH_ANAME : PH_IGNORED;
		endfunction

		function void predict_fields(logic [7:0] b, logic eop);
			parse_result_t r;
			phase_t ph;
			logic [3:0] flen;
			logic flags_seen;
			r = '0;
			r.section = SEC_IGNORED;
			r.field_code = FC_NONE;
			r.parse_error = ERR_OK;
			flags_seen = 1'b0;
			ph = phase;
			case (ph)
				PH_HEADER: begin
					r.section = SEC_HEADER;
					acc = {16'h0000, acc[7:0], b};
					if (hdr_idx[0]) begin
						case (hdr_idx[3:1])
							3'd0: r.field_code = FC_ID;
							3'd1: r.field_code = FC_FLAGS;
							3'd2: r.field_code = FC_QDCOUNT;
							3'd3: r.field_code = FC_ANCOUNT;
							3'd4: r.field_code = FC_NSCOUNT;
							default: r.field_code = FC_ARCOUNT;
						endcase
						r.field_value = acc;
						if (r.field_code == FC_FLAGS) flags_seen = 1'b1;
						if (r.field_code == FC_QDCOUNT) questions_left = acc[15:0];
						if (r.field_code == FC_ANCOUNT) answers = acc[15:0];
						acc = '0;
					end
					if (hdr_idx >= HDR_LAST_IDX) begin
						hdr_idx = '0;
						phase = (questions_left != 0) ? PH_QNAME : after_questions();
					end else begin
						hdr_idx = hdr_idx + 4'd1;
					end
				end
				PH_QNAME, PH_ANAME: begin
					r.section = (ph == PH_QNAME) ? SEC_QUESTION : SEC_ANSWER;
					if (field_pos != 0) begin
						r.field_code = FC_POINTER;
						r.field_value = {18'h0, acc[5:0], b};
						field_pos = '0;
						acc = '0;
						phase = (ph == PH_QNAME) ? PH_QTYPE : PH_ATYPE;
					end else if (bytes_left != 0) begin
						r.field_code = FC_NAME_CHAR;
						r.field_value = {24'h0, b};
						bytes_left = bytes_left - 16'd1;
					end else if (b == 8'h00) begin
						r.field_code = FC_NAME_END;
						phase = (ph == PH_QNAME) ? PH_QTYPE : PH_ATYPE;
					end else if ((b & PTR_TAG_MASK) == PTR_TAG_MASK) begin
						acc = {24'h0, b};
						field_pos = 4'd1;
					end else if (b > LABEL_MAX) begin
						r.parse_error = ERR_LABEL;
						phase = PH_ERROR;
					end else begin
						r.field_code = FC_LABEL_LEN;
						r.field_value = {24'h0, b};
						bytes_left = {8'h00, b};
					end
				end
				PH_QTYPE, PH_QCLASS, PH_ATYPE, PH_ACLASS, PH_ATTL, PH_ARDLEN: begin
					flen = (ph == PH_ATTL) ? LEN_TTL : LEN_SHORT;
					r.section = (ph == PH_QTYPE || ph == PH_QCLASS) ? SEC_QUESTION : SEC_ANSWER;
					acc = (acc << 8) | {24'h0, b};
					field_pos = field_pos + 4'd1;
					if (field_pos >= flen) begin
						r.field_value = acc;
						acc = '0;
						field_pos = '0;
						case (ph)
							PH_QTYPE: begin
								r.field_code = FC_TYPE;
								phase = PH_QCLASS;
							end
							PH_ATYPE: begin
								r.field_code = FC_TYPE;
								phase = PH_ACLASS;
							end
							PH_QCLASS: begin
								r.field_code = FC_CLASS;
								questions_left = questions_left - 16'd1;
								phase = (questions_left != 0) ? PH_QNAME : after_questions();
							end
							PH_ACLASS: begin
								r.field_code = FC_CLASS;
								phase = PH_ATTL;
							end
							PH_ATTL: begin
								r.field_code = FC_TTL;
								phase = PH_ARDLEN;
							end
							default: begin
								r.field_code = FC_RDLENGTH;
								r.field_value = {16'h0, r.field_value[15:0]};
								bytes_left = r.field_value[15:0];
								phase = (bytes_left != 0) ? PH_RDATA : PH_IGNORED;
							end
						endcase
					end
				end
				PH_RDATA: begin
					r.section = SEC_ANSWER;
					r.field_code = FC_RDATA;
					r.field_value = {24'h0, b};
					bytes_left = bytes_left - 16'd1;
					if (bytes_left == 0) phase = PH_IGNORED;
				end
				default: r.section = SEC_IGNORED;
			endcase
			if (eop) begin
				if (r.parse_error == ERR_OK && ph != PH_ERROR && phase != PH_IGNORED)
					r.parse_error = ERR_EARLY_END;
				clear_state();
			end
			if (flags_seen) begin
				r.query_response = r.field_value[15];
				r.op_code = r.field_value[14:11];
				r.authoritative = r.field_value[10];
				r.truncated = r.field_value[9];
				r.recursion_desired = r.field_value[8];
				r.recursion_available = r.field_value[7];
				r.response_code = r.field_value[3:0];
			end
			r.packet_done = eop;
			expected.push_back(r);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
				result_no, what, got, want);
			mismatches++;
		endtask

		task check_one(string what, logic [31:0] got, logic [31:0] want);
			if (got !== want) report_mismatch(what, got, want);
		endtask

		task compare_fields(parse_result_t got);
			parse_result_t want;
			if (expected.size() == 0) begin
				report_mismatch("result without a byte", {28'h0, got.field_code}, '0);
			end else begin
				want = expected.pop_front();
				check_one("section", {30'h0, got.section}, {30'h0, want.section});
				check_one("field_code", {28'h0, got.field_code}, {28'h0, want.field_code});
				check_one("field_value", got.field_value, want.field_value);
				check_one("query_response", {31'h0, got.query_response},
					{31'h0, want.query_response});
				check_one("op_code", {28'h0, got.op_code}, {28'h0, want.op_code});
				check_one("authoritative", {31'h0, got.authoritative},
					{31'h0, want.authoritative});
				check_one("truncated", {31'h0, got.truncated}, {31'h0, want.truncated});
				check_one("recursion_desired", {31'h0, got.recursion_desired},
					{31'h0, want.recursion_desired});
				check_one("recursion_available", {31'h0, got.recursion_available},
					{31'h0, want.recursion_available});
				check_one("response_code", {28'h0, got.response_code},
					{28'h0, want.response_code});
				check_one("parse_error", {30'h0, got.parse_error}, {30'h0, want.parse_error});
				check_one("packet_done", {31'h0, got.packet_done}, {31'h0, want.packet_done});
			end
			result_no++;
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  packet_byte = 8'h00;
	logic        end_of_packet = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  section;
	logic [3:0]  field_code;
	logic [31:0] field_value;
	logic        query_response;
	logic [3:0]  op_code;
	logic        authoritative;
	logic        truncated;
	logic        recursion_desired;
	logic        recursion_available;
	logic [3:0]  response_code;
	logic [1:0]  parse_error;
	logic        packet_done;

	dns_field_checker field_check = new();
	logic [7:0] msg[$];
	int items_sent = 0;
	int hold_request = 0;
	int hold_left = 0;
	bit no_idle = 1'b0;
	int cycle_count = 0;

	dns_message_field_parser_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.packet_byte(packet_byte),
		.end_of_packet(end_of_packet),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.section(section),
		.field_code(field_code),
		.field_value(field_value),
		.query_response(query_response),
		.op_code(op_code),
		.authoritative(authoritative),
		.truncated(truncated),
		.recursion_desired(recursion_desired),
		.recursion_available(recursion_available),
		.response_code(response_code),
		.parse_error(parse_error),
		.packet_done(packet_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("dns_message_field_parser_unit verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			field_check.compare_fields({section, field_code, field_value, query_response,
				op_code, authoritative, truncated, recursion_desired,
				recursion_available, response_code, parse_error, packet_done});
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(99) >= 28);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eop);
		in_valid <= 1'b1;
		packet_byte <= b;
		end_of_packet <= eop;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		field_check.predict_fields(b, eop);
		items_sent++;
		while (!no_idle && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_message();
		for (int i = 0; i < msg.size(); i++)
			send_byte(msg[i], i == msg.size() - 1);
	endtask

	function automatic void add16(logic [15:0] v);
		msg.push_back(v[15:8]);
		msg.push_back(v[7:0]);
	endfunction

	function automatic void add_header(logic [15:0] qd, logic [15:0] an);
		add16(16'($urandom));
		add16(16'($urandom));
		add16(qd);
		add16(an);
		add16(16'($urandom));
		add16(16'($urandom));
	endfunction

	function automatic void add_label(int len);
		msg.push_back(8'(len));
		repeat (len) msg.push_back(8'($urandom));
	endfunction

	function automatic void add_name();
		int labels;
		labels = $urandom_range(0, 3);
		repeat (labels) add_label(($urandom_range(99) < 10) ? 63 : $urandom_range(1, 8));
		if ($urandom_range(99) < 25) begin
			msg.push_back(PTR_TAG_MASK | 8'($urandom_range(63)));
			msg.push_back(8'($urandom));
		end else begin
			msg.push_back(8'h00);
		end
	endfunction

	function automatic void build_well_formed();
		logic [15:0] qd;
		logic [15:0] an;
		int pick;
		int rdlen;
		qd = 16'($urandom_range(0, 3));
		pick = $urandom_range(99);
		an = (pick < 30) ? 16'h0000 : (pick < 85) ? 16'h0001 : 16'($urandom_range(1, 65535));
		add_header(qd, an);
		repeat (qd) begin
			add_name();
			add16(16'($urandom));
			add16(16'($urandom));
		end
		if (an != 0) begin
			add_name();
			add16(16'($urandom));
			add16(16'($urandom));
			add16(16'($urandom));
			add16(16'($urandom));
			rdlen = ($urandom_range(99) < 15) ? 0 : $urandom_range(1, 8);
			add16(16'(rdlen));
			repeat (rdlen) msg.push_back(8'($urandom));
		end
		repeat ($urandom_range(0, 4)) msg.push_back(8'($urandom));
	endfunction

	function automatic void build_bad_label();
		logic [15:0] qd;
		qd = 16'($urandom_range(0, 1));
		add_header(qd, 16'h0001);
		if ($urandom_range(1) == 1) add_label($urandom_range(1, 5));
		msg.push_back(8'($urandom_range(8'h40, 8'hBF)));
		repeat ($urandom_range(0, 5)) msg.push_back(8'($urandom));
	endfunction

	initial begin
		int msg_count;
		int pick;
		int keep;
		msg_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Header only, zero question and answer counts, all flag bits set.
		msg.delete();
		add16(16'h0000);
		add16(16'hFFFF);
		add16(16'h0000);
		add16(16'h0000);
		add16(16'hFFFF);
		add16(16'h0000);
		send_message();
		// One question whose first length byte is out of range, ending the message.
		msg.delete();
		add16(16'hFFFF);
		add16(16'h0000);
		add16(16'h0001);
		add16(16'h0000);
		add16(16'h0000);
		add16(16'hFFFF);
		msg.push_back(8'hBF);
		send_message();

		while (items_sent < ITEM_TARGET) begin
			msg.delete();
			pick = $urandom_range(99);
			if (pick < 65) begin
				build_well_formed();
			end else if (pick < 80) begin
				build_well_formed();
				keep = $urandom_range(1, msg.size());
				while (msg.size() > keep) void'(msg.pop_back());
			end else if (pick < 92) begin
				build_bad_label();
			end else begin
				repeat ($urandom_range(1, 30)) msg.push_back(8'($urandom));
			end
			if (msg_count == 6) hold_request = 200;
			no_idle = (msg_count >= 25 && msg_count < 40);
			send_message();
			if (msg_count == 15) begin
				in_valid <= 1'b0;
				while (field_check.pending() != 0) @(posedge clk);
			end
			msg_count++;
		end
		in_valid <= 1'b0;
		no_idle = 1'b0;
		while (field_check.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (field_check.mismatches == 0) begin
			$display("dns_message_field_parser_unit verification clean");
		end else begin
			$display("dns_message_field_parser_unit verification failed");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/dmfp_pkg.sv
hw/rtl/dmfp_decode.sv
hw/rtl/dns_message_field_parser_unit.sv
hw/rtl/dmfp_checker.sv
verif/dns_message_field_parser_unit_test.sv
